FILE: rtl/ensemble_anomaly_detector_macros.svh
// ============================================================================
// Assertion macros for the ensemble anomaly detector
// Short forms for clocked assertions that are disabled during reset.
// ============================================================================
`ifndef ENSEMBLE_ANOMALY_DETECTOR_MACROS_SVH
`define ENSEMBLE_ANOMALY_DETECTOR_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define EAD_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: invariant");

// The consequent holds in the same cycle as the antecedent.
`define EAD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent holds in the cycle after the antecedent.
`define EAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/ead_pkg.sv
// ============================================================================
// ead_pkg
// Shared types, constants and codes of the ensemble anomaly detector.
// ============================================================================
package ead_pkg;

  localparam int WINDOW_DEFAULT = 20;
  localparam int CFG_IDX_W      = 3;
  localparam int DATA_W         = 32;
  localparam int X_W            = 48;  // Q16.32 position estimate
  localparam int G_W            = 25;  // Q1.24 gain, reaches 1.0 when r is zero
  localparam int FRAC_SH        = 24;
  localparam int RUN_W          = 9;
  localparam int DIV_N_W        = 56;
  localparam int DIV_D_W        = 33;

  localparam logic [31:0]      P_ONE        = 32'h0100_0000;
  localparam logic [7:0]       PERSIST_RST  = 8'd2;
  localparam logic [31:0]      QNOISE_RST   = 32'd1678;
  localparam logic [31:0]      RNOISE_RST   = 32'd1677722;
  localparam logic [RUN_W-1:0] RUN_MAX      = 9'd511;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLEW_LIMIT        = 3'd0,
    CFG_SPREAD_LIMIT      = 3'd1,
    CFG_INNOVATION_LIMIT  = 3'd2,
    CFG_PERSISTENCE       = 3'd3,
    CFG_PROCESS_NOISE     = 3'd4,
    CFG_MEASUREMENT_NOISE = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MUL_NS2,
    MUL_S1S,
    MUL_D,
    MUL_P
  } mul_sel_t;

  typedef enum logic {
    DIV_ROOT,
    DIV_GAIN
  } div_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_STORE,
    ST_WALK_GO,
    ST_WALK_WAIT,
    ST_NS2_GO,
    ST_NS2_WAIT,
    ST_S1S_GO,
    ST_S1S_WAIT,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DIVR_GO,
    ST_DIVR_WAIT,
    ST_KAL_CHECK,
    ST_GAIN_GO,
    ST_GAIN_WAIT,
    ST_DMUL_GO,
    ST_DMUL_WAIT,
    ST_PMUL_GO,
    ST_PMUL_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic        restart;
    logic        load;
    logic        store;
    logic        walk_start;
    logic        mul_start;
    mul_sel_t    mul_sel;
    logic        sqrt_start;
    logic        div_start;
    div_sel_t    div_sel;
    logic        cap_ns2;
    logic        cap_m;
    logic        cap_spread;
    logic        cap_g;
    logic        cap_x;
    logic        cap_p;
    logic        kal_first;
    logic        finish;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic mul_done;
    logic sqrt_done;
    logic div_done;
    logic started;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [30:0] slew_limit;
    logic [30:0] spread_limit;
    logic [30:0] innovation_limit;
    logic [7:0]  persistence;
    logic [31:0] process_noise;
    logic [31:0] measurement_noise;
  } cfg_t;

endpackage

FILE: rtl/ead_mul.sv
// ============================================================================
// ead_mul
// Shift-and-add multiplier, one bit of the second operand per cycle.
// ============================================================================
module ead_mul #(
  parameter int MA_W = 69,
  parameter int MB_W = 37
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [MA_W-1:0]      a,
  input  logic [MB_W-1:0]      b,
  output logic                 done,
  output logic [MA_W+MB_W-1:0] prod
);
  import ead_pkg::*;

  localparam int P_W   = MA_W + MB_W;
  localparam int CNT_W = $clog2(MB_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [P_W-1:0]   a_sh;
  logic [MB_W-1:0]  b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(MB_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= P_W'(a);
      b_sh <= b;
      prod <= '0;
    end else if (busy) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

FILE: rtl/ead_div.sv
// ============================================================================
// ead_div
// Restoring divider, one quotient bit per cycle.
// ============================================================================
module ead_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ead_pkg::DIV_N_W-1:0] dividend,
  input  logic [ead_pkg::DIV_D_W-1:0] divisor,
  output logic                        done,
  output logic [ead_pkg::DIV_N_W-1:0] quot
);
  import ead_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DIV_N_W-1:0] num;
  logic [DIV_D_W-1:0] den;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W:0]   rem_sh;
  logic [DIV_D_W:0]   rem_sub;
  logic               fits;

  assign rem_sh  = {rem, num[DIV_N_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign fits    = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= dividend;
      den  <= divisor;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      num <= num << 1;
      if (fits) begin
        rem  <= rem_sub[DIV_D_W-1:0];
        quot <= {quot[DIV_N_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[DIV_D_W-1:0];
        quot <= {quot[DIV_N_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/ead_sqrt.sv
// ============================================================================
// ead_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ============================================================================
module ead_sqrt #(
  parameter int M_W = 74
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [M_W-1:0]   radicand,
  output logic             done,
  output logic [M_W/2-1:0] root
);
  import ead_pkg::*;

  localparam int R_W   = M_W / 2;
  localparam int CNT_W = $clog2(R_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [M_W-1:0]   m_sh;
  logic [R_W+1:0]   rem;
  logic [R_W+3:0]   rem_sh;
  logic [R_W+3:0]   trial;
  logic [R_W+3:0]   rem_sub;

  assign rem_sh  = {rem, m_sh[M_W-1:M_W-2]};
  assign trial   = (R_W + 4)'({root, 2'b01});
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(R_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m_sh <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      m_sh <= m_sh << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sub[R_W+1:0];
        root <= {root[R_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[R_W+1:0];
        root <= {root[R_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/ead_dp.sv
// ============================================================================
// ead_dp
// Datapath: sample window, sums, Kalman state, arithmetic units and the
// output register.
// ============================================================================
module ead_dp #(
  parameter int WINDOW = ead_pkg::WINDOW_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  ead_pkg::cmd_t    cmd,
  output ead_pkg::status_t status,
  input  ead_pkg::cfg_t    cfg,
  input  logic [31:0]      sample,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      echoed_sample,
  output logic [31:0]      slew_error,
  output logic [31:0]      spread_value,
  output logic [31:0]      innovation_error,
  output logic             alarm
);
  import ead_pkg::*;

  localparam int AW   = $clog2(WINDOW);
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int S1_W = 32 + CW;
  localparam int S2_W = 64 + CW;
  localparam int M_W  = 64 + 2 * CW;
  localparam int R_W  = M_W / 2;
  localparam int MA_W = S2_W;
  localparam int MB_W = S1_W;
  localparam int P_W  = MA_W + MB_W;

  // Stored state
  logic [31:0]      sample_reg;
  logic [31:0]      prev_sample;
  logic             prev_valid;
  logic [31:0]      mem [WINDOW];
  logic [AW-1:0]    wpos;
  logic [CW-1:0]    fill;
  logic [X_W-1:0]   x_est;
  logic [31:0]      p_cov;
  logic             started;
  logic [RUN_W-1:0] run;

  // Per-sample working registers
  logic [31:0]      slew_r;
  logic [31:0]      p_pred;
  logic [X_W-1:0]   mag;
  logic             e_neg;
  logic [31:0]      innov_r;
  logic [M_W-1:0]   ns2;
  logic [M_W-1:0]   m_r;
  logic [31:0]      spread_r;
  logic [G_W-1:0]   g_r;

  // Window walk
  logic             walk_busy;
  logic [CW-1:0]    idx;
  logic             walk_rd_en;
  logic             rd_v;
  logic [31:0]      rd_data;
  logic             sq_v;
  logic [31:0]      sq_x;
  logic [63:0]      sq;
  logic [31:0]      rd_biased;
  logic [S1_W-1:0]  s1;
  logic [S2_W-1:0]  s2;
  logic             walk_done;

  // Combinational terms
  logic [32:0]      slew_diff;
  logic [32:0]      slew_abs;
  logic [31:0]      slew_sat;
  logic [X_W-1:0]   target;
  logic [X_W:0]     e_full;
  logic [X_W:0]     e_abs;
  logic [33:0]      p_sum;
  logic [31:0]      p_pred_next;
  logic [X_W-1:0]   d_step;
  logic             suspect;
  logic [RUN_W-1:0] run_next;

  // Arithmetic units
  logic [MA_W-1:0]    mul_a;
  logic [MB_W-1:0]    mul_b;
  logic               mul_done;
  logic [P_W-1:0]     prod;
  logic [DIV_N_W-1:0] div_n;
  logic [DIV_D_W-1:0] div_d;
  logic               div_done;
  logic [DIV_N_W-1:0] quot;
  logic               sqrt_done;
  logic [R_W-1:0]     root;

  assign slew_diff   = {sample_reg[31], sample_reg} - {prev_sample[31], prev_sample};
  assign slew_abs    = slew_diff[32] ? (~slew_diff + 33'd1) : slew_diff;
  assign slew_sat    = slew_abs[32] ? '1 : slew_abs[31:0];
  assign target      = {sample_reg, 16'h0000};
  assign e_full      = {target[X_W-1], target} - {x_est[X_W-1], x_est};
  assign e_abs       = e_full[X_W] ? (~e_full + 1'b1) : e_full;
  assign p_sum       = {2'b00, p_cov} + {2'b00, P_ONE} + {2'b00, cfg.process_noise};
  assign p_pred_next = (|p_sum[33:32]) ? '1 : p_sum[31:0];
  assign d_step      = prod[FRAC_SH +: X_W];

  assign suspect = (slew_r > {1'b0, cfg.slew_limit})
                || (spread_r > {1'b0, cfg.spread_limit})
                || (innov_r > {1'b0, cfg.innovation_limit});
  assign run_next = !suspect ? '0 : ((run == RUN_MAX) ? run : run + 1'b1);

  // Sample capture, window store and running filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_valid <= 1'b0;
      wpos       <= '0;
      fill       <= '0;
      started    <= 1'b0;
      run        <= '0;
      p_cov      <= P_ONE;
    end else if (cmd.restart) begin
      prev_valid <= 1'b0;
      wpos       <= '0;
      fill       <= '0;
      started    <= 1'b0;
      run        <= '0;
      p_cov      <= P_ONE;
    end else begin
      if (cmd.store) begin
        wpos <= (wpos == AW'(WINDOW - 1)) ? '0 : wpos + 1'b1;
        if (fill < CW'(WINDOW)) begin
          fill <= fill + 1'b1;
        end
      end
      if (cmd.kal_first) begin
        started <= 1'b1;
      end
      if (cmd.cap_p) begin
        p_cov <= p_pred - prod[FRAC_SH +: 32];
      end
      if (cmd.finish) begin
        prev_valid <= 1'b1;
        run        <= run_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_reg <= sample;
    end
    if (cmd.store) begin
      slew_r  <= prev_valid ? slew_sat : '0;
      mag     <= e_abs[X_W-1:0];
      e_neg   <= e_full[X_W];
      p_pred  <= p_pred_next;
      innov_r <= started ? e_abs[X_W-1:16] : '0;
    end
    if (cmd.kal_first) begin
      x_est <= target;
    end else if (cmd.cap_x) begin
      x_est <= e_neg ? (x_est - d_step) : (x_est + d_step);
    end
    if (cmd.cap_ns2) begin
      ns2 <= prod[M_W-1:0];
    end
    if (cmd.cap_m) begin
      m_r <= ns2 - prod[M_W-1:0];
    end
    if (cmd.cap_spread) begin
      spread_r <= (|quot[DIV_N_W-1:32]) ? '1 : quot[31:0];
    end
    if (cmd.cap_g) begin
      g_r <= quot[G_W-1:0];
    end
    if (cmd.finish) begin
      prev_sample <= sample_reg;
    end
  end

  // Window memory: one write port, one registered read port.
  assign walk_rd_en = walk_busy && (idx != fill);

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[wpos] <= sample_reg;
    end
    if (walk_rd_en) begin
      rd_data <= mem[idx[AW-1:0]];
    end
  end

  // Walk over the filled entries: read, square, accumulate.
  assign walk_done = walk_busy && (idx == fill) && !rd_v && !sq_v;
  assign rd_biased = rd_data ^ 32'h8000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_busy <= 1'b0;
      idx       <= '0;
      rd_v      <= 1'b0;
      sq_v      <= 1'b0;
    end else begin
      rd_v <= walk_rd_en;
      sq_v <= rd_v;
      if (cmd.walk_start) begin
        walk_busy <= 1'b1;
        idx       <= '0;
      end else if (walk_done) begin
        walk_busy <= 1'b0;
      end else if (walk_rd_en) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v) begin
      sq_x <= rd_biased;
      sq   <= rd_biased * rd_biased;
    end
    if (cmd.walk_start) begin
      s1 <= '0;
      s2 <= '0;
    end else if (sq_v) begin
      s1 <= s1 + S1_W'(sq_x);
      s2 <= s2 + S2_W'(sq);
    end
  end

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    case (cmd.mul_sel)
      MUL_NS2: begin
        mul_a = s2;
        mul_b = MB_W'(fill);
      end
      MUL_S1S: begin
        mul_a = MA_W'(s1);
        mul_b = s1;
      end
      MUL_D: begin
        mul_a = MA_W'(mag);
        mul_b = MB_W'(g_r);
      end
      MUL_P: begin
        mul_a = MA_W'(p_pred);
        mul_b = MB_W'(g_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_ROOT: begin
        div_n = DIV_N_W'(root);
        div_d = DIV_D_W'(fill);
      end
      DIV_GAIN: begin
        div_n = {p_pred, 24'h000000};
        div_d = {1'b0, p_pred} + {1'b0, cfg.measurement_noise};
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase
  end

  ead_mul #(
    .MA_W (MA_W),
    .MB_W (MB_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  ead_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (quot)
  );

  ead_sqrt #(
    .M_W (M_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (m_r),
    .done     (sqrt_done),
    .root     (root)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      echoed_sample    <= sample_reg;
      slew_error       <= slew_r;
      spread_value     <= spread_r;
      innovation_error <= innov_r;
      alarm            <= (run_next != '0) && (run_next <= RUN_W'(cfg.persistence));
    end
  end

  assign status.walk_done = walk_done;
  assign status.mul_done  = mul_done;
  assign status.sqrt_done = sqrt_done;
  assign status.div_done  = div_done;
  assign status.started   = started;
  assign status.out_free  = !out_valid || !out_stall;

endmodule

FILE: rtl/ead_ctrl.sv
// ============================================================================
// ead_ctrl
// Sequencer that steps each sample through store, window walk, spread and
// Kalman update, issuing commands to the datapath.
// ============================================================================
module ead_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             operation,
  output logic             in_stall,
  output ead_pkg::cmd_t    cmd,
  input  ead_pkg::status_t status
);
  import ead_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !operation) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE:     state_next = ST_WALK_GO;
      ST_WALK_GO:   state_next = ST_WALK_WAIT;
      ST_WALK_WAIT: begin
        if (status.walk_done) begin
          state_next = ST_NS2_GO;
        end
      end
      ST_NS2_GO:    state_next = ST_NS2_WAIT;
      ST_NS2_WAIT: begin
        if (status.mul_done) begin
          state_next = ST_S1S_GO;
        end
      end
      ST_S1S_GO:    state_next = ST_S1S_WAIT;
      ST_S1S_WAIT: begin
        if (status.mul_done) begin
          state_next = ST_SQRT_GO;
        end
      end
      ST_SQRT_GO:   state_next = ST_SQRT_WAIT;
      ST_SQRT_WAIT: begin
        if (status.sqrt_done) begin
          state_next = ST_DIVR_GO;
        end
      end
      ST_DIVR_GO:   state_next = ST_DIVR_WAIT;
      ST_DIVR_WAIT: begin
        if (status.div_done) begin
          state_next = ST_KAL_CHECK;
        end
      end
      ST_KAL_CHECK: begin
        state_next = status.started ? ST_GAIN_GO : ST_FINISH;
      end
      ST_GAIN_GO:   state_next = ST_GAIN_WAIT;
      ST_GAIN_WAIT: begin
        if (status.div_done) begin
          state_next = ST_DMUL_GO;
        end
      end
      ST_DMUL_GO:   state_next = ST_DMUL_WAIT;
      ST_DMUL_WAIT: begin
        if (status.mul_done) begin
          state_next = ST_PMUL_GO;
        end
      end
      ST_PMUL_GO:   state_next = ST_PMUL_WAIT;
      ST_PMUL_WAIT: begin
        if (status.mul_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_NS2;
    cmd.div_sel = DIV_ROOT;
    in_stall    = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.restart = in_valid && operation;
        cmd.load    = in_valid && !operation;
      end
      ST_STORE:     cmd.store = 1'b1;
      ST_WALK_GO:   cmd.walk_start = 1'b1;
      ST_NS2_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_NS2;
      end
      ST_NS2_WAIT:  cmd.cap_ns2 = status.mul_done;
      ST_S1S_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_S1S;
      end
      ST_S1S_WAIT:  cmd.cap_m = status.mul_done;
      ST_SQRT_GO:   cmd.sqrt_start = 1'b1;
      ST_DIVR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ROOT;
      end
      ST_DIVR_WAIT: cmd.cap_spread = status.div_done;
      ST_KAL_CHECK: cmd.kal_first = !status.started;
      ST_GAIN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_GAIN;
      end
      ST_GAIN_WAIT: cmd.cap_g = status.div_done;
      ST_DMUL_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_D;
      end
      ST_DMUL_WAIT: cmd.cap_x = status.mul_done;
      ST_PMUL_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_P;
      end
      ST_PMUL_WAIT: cmd.cap_p = status.mul_done;
      ST_FINISH:    cmd.finish = status.out_free;
      default:      cmd = '0;
    endcase
  end

endmodule

FILE: rtl/ensemble_anomaly_detector.sv
// ============================================================================
// ensemble_anomaly_detector
// Three-way anomaly check of Q16.16 samples: slew, window spread and
// Kalman innovation, with a persistence-limited alarm.
// ============================================================================
// Usage:
//   Input transfers happen when in_valid is high and in_stall is low. An item
//   with operation set restarts the detector state and gives no result; an
//   item with operation clear is a sample and gives one result.
//   Results leave through a registered output: a transfer happens when
//   out_valid is high and out_stall is low. While the receiver stalls, the
//   result holds; the block may already take the next sample and work on it,
//   and waits at the end of that sample until the output register is free.
//   The time a sample takes grows with n, the number of window entries held,
//   and is set by the serial units: the bit-serial multiplier, the
//   square-root unit and the divider, and the one-entry-a-cycle walk of the
//   window memory. The first sample after a restart skips the gain division
//   and the two filter multiplications.
//   Reset (synchronous, active high) restores the register defaults and the
//   restart state; the window memory needs no clearing, since only entries
//   written since the last restart are ever read.
//   Configuration writes are taken on any cycle cfg_write_enable is high.
// ============================================================================
`include "ensemble_anomaly_detector_macros.svh"

module ensemble_anomaly_detector #(
  parameter int WINDOW = ead_pkg::WINDOW_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_enable,
  input  logic [ead_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ead_pkg::DATA_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          operation,
  input  logic signed [31:0]            sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            echoed_sample,
  output logic [31:0]                   slew_error,
  output logic [31:0]                   spread_value,
  output logic [31:0]                   innovation_error,
  output logic                          alarm
);
  import ead_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic [31:0] echoed_raw;

  // Configuration registers. Each write keeps only the bits the register
  // holds; writes to an index beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slew_limit        <= '0;
      cfg.spread_limit      <= '0;
      cfg.innovation_limit  <= '0;
      cfg.persistence       <= PERSIST_RST;
      cfg.process_noise     <= QNOISE_RST;
      cfg.measurement_noise <= RNOISE_RST;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_SLEW_LIMIT:        cfg.slew_limit        <= cfg_data[30:0];
        CFG_SPREAD_LIMIT:      cfg.spread_limit      <= cfg_data[30:0];
        CFG_INNOVATION_LIMIT:  cfg.innovation_limit  <= cfg_data[30:0];
        CFG_PERSISTENCE:       cfg.persistence       <= cfg_data[7:0];
        CFG_PROCESS_NOISE:     cfg.process_noise     <= cfg_data;
        CFG_MEASUREMENT_NOISE: cfg.measurement_noise <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The sequencer decides what happens each cycle; the datapath holds all
  // sample state and the shared arithmetic units.
  ead_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .status    (status)
  );

  ead_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg              (cfg),
    .sample           (sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .echoed_sample    (echoed_raw),
    .slew_error       (slew_error),
    .spread_value     (spread_value),
    .innovation_error (innovation_error),
    .alarm            (alarm)
  );

  assign echoed_sample = echoed_raw;

  // A sample transfer always makes the block busy in the next cycle.
  `EAD_ASSERT_NEXT(a_sample_busy, clk, rst, in_valid && !in_stall && !operation, in_stall)
  // A restart completes at once and leaves the block ready.
  `EAD_ASSERT_NEXT(a_restart_ready, clk, rst, in_valid && !in_stall && operation, !in_stall)
  // A new result is never written over one the receiver has not taken.
  `EAD_ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.finish, !out_valid || !out_stall)
  // At most one arithmetic unit is launched per cycle.
  `EAD_ASSERT_ALWAYS(a_one_launch, clk, rst,
    $onehot0({cmd.walk_start, cmd.mul_start, cmd.sqrt_start, cmd.div_start}))

endmodule
